// ----- sv/led_flash_sequencer_defines.svh -----
// assertion macros for the led flash sequencer
// no dependencies; included by the top level only
`ifndef LED_FLASH_SEQUENCER_DEFINES_SVH
`define LED_FLASH_SEQUENCER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, disabled while in reset
`define LFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("led flash sequencer check failed");
// next-cycle implication, disabled while in reset
`define LFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("led flash sequencer check failed");
`else
`define LFS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/lfs_pkg.sv -----
// types, codes and constants of the led flash sequencer
// no dependencies; imported by every other source file but the defines header
package lfs_pkg;

  localparam int unsigned MS_W    = 32;
  localparam int unsigned US_W    = 32;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'hFF;

  // sequence steps
  typedef enum logic [2:0] {
    STEP_IDLE     = 3'd0,
    STEP_DELAY    = 3'd1,
    STEP_ON       = 3'd2,
    STEP_ON_TIME  = 3'd3,
    STEP_OFF      = 3'd4,
    STEP_OFF_TIME = 3'd5,
    STEP_COUNT    = 3'd6,
    STEP_PAUSE    = 3'd7
  } step_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ON_TIME     = 3'd0,
    CFG_OFF_TIME    = 3'd1,
    CFG_PAUSE_TIME  = 3'd2,
    CFG_START_DELAY = 3'd3,
    CFG_PULSES      = 3'd4,
    CFG_RAMP_STEP   = 3'd5,
    CFG_DIM_LEVEL   = 3'd6,
    CFG_INVERT      = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [TIME_W-1:0]  on_time_ms;
    logic [TIME_W-1:0]  off_time_ms;
    logic [TIME_W-1:0]  pause_time_ms;
    logic [TIME_W-1:0]  start_delay_ms;
    logic [COUNT_W-1:0] pulses_per_burst;
    logic [TIME_W-1:0]  ramp_step_us;
    logic [LEVEL_W-1:0] dim_level;
    logic               invert_output;
  } lfs_cfg_t;

  // ramp direction flags
  typedef struct packed {
    logic rising;
    logic falling;
  } ramp_dir_t;

  typedef struct packed {
    step_t              step;
    logic [MS_W-1:0]    phase_mark_ms;
    logic [COUNT_W-1:0] pulse_counter;
    ramp_dir_t          dir;
    logic               on_phase;
  } seq_state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [US_W-1:0]    ramp_mark_us;
  } ramp_state_t;

endpackage

// ----- sv/lfs_if.sv -----
// valid/ready channel interfaces for timestamp items and results
// depends on lfs_pkg
interface lfs_in_if import lfs_pkg::*;;
  logic            valid;
  logic            ready;
  logic [MS_W-1:0] now_ms;
  logic [US_W-1:0] now_us;
  logic            restart;

  modport source (output valid, output now_ms, output now_us, output restart, input ready);
  modport sink (input valid, input now_ms, input now_us, input restart, output ready);
endinterface

interface lfs_out_if import lfs_pkg::*;;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] led_level;
  logic               pulse_on_phase;

  modport source (output valid, output led_level, output pulse_on_phase, input ready);
  modport sink (input valid, input led_level, input pulse_on_phase, output ready);
endinterface

// ----- sv/lfs_seq.sv -----
// flash sequence step logic: next step, phase mark, pulse count and flags
// depends on lfs_pkg
module lfs_seq import lfs_pkg::*; (
  input  seq_state_t      cur,
  input  lfs_cfg_t        cfg,
  input  logic [MS_W-1:0] now_ms,
  input  logic            restart,
  output seq_state_t      nxt
);

  step_t              step_in;
  logic [COUNT_W-1:0] count_in;
  logic [TIME_W-1:0]  span;
  logic [MS_W-1:0]    age;
  logic               elapsed;
  logic               burst_done;

  // restart clears step and count before stepping
  assign step_in  = restart ? STEP_IDLE : cur.step;
  assign count_in = restart ? '0 : cur.pulse_counter;

  // one shared timer compare, span picked by the waiting step
  always_comb begin
    unique case (step_in)
      STEP_DELAY:    span = cfg.start_delay_ms;
      STEP_ON_TIME:  span = cfg.on_time_ms;
      STEP_OFF_TIME: span = cfg.off_time_ms;
      STEP_PAUSE:    span = cfg.pause_time_ms;
      default:       span = '0;
    endcase
  end

  assign age        = now_ms - cur.phase_mark_ms;
  assign elapsed    = age >= {{(MS_W-TIME_W){1'b0}}, span};
  assign burst_done = count_in >= cfg.pulses_per_burst;

  // next step
  always_comb begin
    unique case (step_in)
      STEP_IDLE:     nxt.step = STEP_DELAY;
      STEP_DELAY:    nxt.step = elapsed ? STEP_ON : STEP_DELAY;
      STEP_ON:       nxt.step = STEP_ON_TIME;
      STEP_ON_TIME:  nxt.step = elapsed ? STEP_OFF : STEP_ON_TIME;
      STEP_OFF:      nxt.step = STEP_OFF_TIME;
      STEP_OFF_TIME: nxt.step = elapsed ? STEP_COUNT : STEP_OFF_TIME;
      STEP_COUNT:    nxt.step = burst_done ? STEP_PAUSE : STEP_ON;
      STEP_PAUSE:    nxt.step = elapsed ? STEP_ON : STEP_PAUSE;
    endcase
  end

  // marks, count and flags
  always_comb begin
    nxt.phase_mark_ms = cur.phase_mark_ms;
    nxt.pulse_counter = count_in;
    nxt.dir           = cur.dir;
    nxt.on_phase      = cur.on_phase;
    unique case (step_in)
      STEP_IDLE: begin
        nxt.phase_mark_ms = now_ms;
      end
      STEP_ON: begin
        nxt.dir.rising    = 1'b1;
        nxt.dir.falling   = 1'b0;
        nxt.pulse_counter = count_in + COUNT_W'(1);
        nxt.phase_mark_ms = now_ms;
        nxt.on_phase      = 1'b1;
      end
      STEP_ON_TIME: begin
        if (elapsed) begin
          nxt.on_phase = 1'b0;
        end
      end
      STEP_OFF: begin
        nxt.dir.falling   = 1'b1;
        nxt.dir.rising    = 1'b0;
        nxt.phase_mark_ms = now_ms;
      end
      STEP_COUNT: begin
        if (burst_done) begin
          nxt.pulse_counter = '0;
          nxt.phase_mark_ms = now_ms;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sv/lfs_ramp.sv -----
// brightness ramp: one level per interval, or an immediate jump
// depends on lfs_pkg
module lfs_ramp import lfs_pkg::*; (
  input  ramp_state_t     cur,
  input  ramp_dir_t       dir_in,
  input  lfs_cfg_t        cfg,
  input  logic [US_W-1:0] now_us,
  output ramp_state_t     nxt,
  output ramp_dir_t       dir_out
);

  logic [US_W-1:0]    age;
  logic               tick;
  logic [LEVEL_W-1:0] lvl_up;
  logic [LEVEL_W-1:0] lvl_dn;

  assign age  = now_us - cur.ramp_mark_us;
  assign tick = age >= {{(US_W-TIME_W){1'b0}}, cfg.ramp_step_us};

  assign lvl_up = (dir_in.rising && cur.level != FULL_LEVEL) ? cur.level + LEVEL_W'(1)
                                                              : cur.level;
  assign lvl_dn = (dir_in.falling && lvl_up > cfg.dim_level) ? lvl_up - LEVEL_W'(1) : lvl_up;

  always_comb begin
    nxt     = cur;
    dir_out = dir_in;
    if (cfg.ramp_step_us != '0) begin
      if (tick) begin
        nxt.ramp_mark_us = now_us;
        nxt.level        = lvl_dn;
        if (lvl_up == FULL_LEVEL || dir_in.falling) begin
          dir_out.rising = 1'b0;
        end
        if (lvl_dn == cfg.dim_level) begin
          dir_out.falling = 1'b0;
        end
      end
    end else begin
      // falling wins when both are set, as it is applied last
      if (dir_in.rising) begin
        nxt.level      = FULL_LEVEL;
        dir_out.rising = 1'b0;
      end
      if (dir_in.falling) begin
        nxt.level       = cfg.dim_level;
        dir_out.falling = 1'b0;
      end
    end
  end

endmodule

// ----- sv/led_flash_sequencer.sv -----
// each accepted input transaction gives one result transaction, in order of arrival
// throughput: one transaction per cycle while the receiver is ready, set by the state update loop
// input register -> sequence/ramp logic -> result register, with no bubbles
// reset (rst_n low, synchronous): sequence idle, counters, marks and level cleared,
// configuration back to defaults (pulses_per_burst = 1, all others 0)
`include "led_flash_sequencer_defines.svh"

module led_flash_sequencer import lfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  lfs_in_if.sink                in_ch,
  lfs_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  lfs_cfg_t cfg_r;

  // input register stage
  logic            s1_valid_r;
  logic [MS_W-1:0] now_ms_r;
  logic [US_W-1:0] now_us_r;
  logic            restart_r;

  // sequencer state
  seq_state_t  seq_r;
  seq_state_t  seq_nxt;
  seq_state_t  seq_upd_nxt;
  ramp_state_t ramp_r;
  ramp_state_t ramp_nxt;
  ramp_dir_t   dir_nxt;

  // result register
  logic               out_valid_r;
  logic [LEVEL_W-1:0] led_level_r;
  logic               on_phase_r;
  logic [LEVEL_W-1:0] drive_nxt;

  // the stage-1 item moves on when the result register is empty or being drained
  logic advance;
  logic in_fire;

  assign advance  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_fire  = in_ch.valid && in_ch.ready;

  // configuration writes, expected only while idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_time_ms       <= '0;
      cfg_r.off_time_ms      <= '0;
      cfg_r.pause_time_ms    <= '0;
      cfg_r.start_delay_ms   <= '0;
      cfg_r.pulses_per_burst <= COUNT_W'(1);
      cfg_r.ramp_step_us     <= '0;
      cfg_r.dim_level        <= '0;
      cfg_r.invert_output    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ON_TIME:     cfg_r.on_time_ms       <= cfg_wdata;
        CFG_OFF_TIME:    cfg_r.off_time_ms      <= cfg_wdata;
        CFG_PAUSE_TIME:  cfg_r.pause_time_ms    <= cfg_wdata;
        CFG_START_DELAY: cfg_r.start_delay_ms   <= cfg_wdata;
        CFG_PULSES:      cfg_r.pulses_per_burst <= cfg_wdata[COUNT_W-1:0];
        CFG_RAMP_STEP:   cfg_r.ramp_step_us     <= cfg_wdata;
        CFG_DIM_LEVEL:   cfg_r.dim_level        <= cfg_wdata[LEVEL_W-1:0];
        CFG_INVERT:      cfg_r.invert_output    <= cfg_wdata[0];
      endcase
    end
  end

  // input register: holds one timestamp transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      now_ms_r  <= in_ch.now_ms;
      now_us_r  <= in_ch.now_us;
      restart_r <= in_ch.restart;
    end
  end

  // sequence step, then ramp on the updated direction flags
  lfs_seq u_seq (
    .cur     (seq_r),
    .cfg     (cfg_r),
    .now_ms  (now_ms_r),
    .restart (restart_r),
    .nxt     (seq_nxt)
  );

  lfs_ramp u_ramp (
    .cur     (ramp_r),
    .dir_in  (seq_nxt.dir),
    .cfg     (cfg_r),
    .now_us  (now_us_r),
    .nxt     (ramp_nxt),
    .dir_out (dir_nxt)
  );

  // sequence state with the direction flags as the ramp leaves them
  always_comb begin
    seq_upd_nxt     = seq_nxt;
    seq_upd_nxt.dir = dir_nxt;
  end

  // optional inversion for active-low drivers
  assign drive_nxt = cfg_r.invert_output ? (FULL_LEVEL - ramp_nxt.level) : ramp_nxt.level;

  // state update, once per item leaving the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= '0;
      ramp_r <= '0;
    end else if (advance) begin
      seq_r  <= seq_upd_nxt;
      ramp_r <= ramp_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      led_level_r <= drive_nxt;
      on_phase_r  <= seq_nxt.on_phase;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.led_level      = led_level_r;
  assign out_ch.pulse_on_phase = on_phase_r;

  // the on-time step is only reached through the pulse start, which raises the flag
  `LFS_ASSERT_NOW(a_on_time_flag, clk, rst_n, seq_r.step == STEP_ON_TIME, seq_r.on_phase)
  // a pause always starts with a cleared pulse count
  `LFS_ASSERT_NOW(a_pause_count, clk, rst_n, seq_r.step == STEP_PAUSE, seq_r.pulse_counter == '0)
  // an item leaving the input register always lands in the result register
  `LFS_ASSERT_NEXT(a_result_loaded, clk, rst_n, advance, out_valid_r)
  // a stalled input stage keeps its item
  `LFS_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_r && !advance, s1_valid_r)

endmodule

// ----- test/led_flash_sequencer_tb.sv -----
// self-checking testbench for the led flash sequencer: timestamp transactions in, drive levels out
// depends on lfs_pkg, lfs_in_if, lfs_out_if and the led_flash_sequencer top level
`timescale 1ns / 100ps

module led_flash_sequencer_tb;
  import lfs_pkg::*;

  // one result transaction as the block should present it
  typedef struct packed {
    logic [LEVEL_W-1:0] led_level;
    logic               pulse_on_phase;
  } drive_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lfs_in_if  in_ch();
  lfs_out_if out_ch();

  led_flash_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the registers and of the sequencer state
  lfs_cfg_t           shadow_cfg;
  step_t              flash_step;
  logic [MS_W-1:0]    flash_mark_ms;
  logic [US_W-1:0]    ramp_mark_us;
  logic [COUNT_W-1:0] pulses_done;
  logic [LEVEL_W-1:0] brightness;
  logic               going_up;
  logic               going_down;
  logic               lit_phase;

  // drive levels still owed by the block, oldest first
  drive_t expected_drive[$];
  int unsigned mismatch_count = 0;

  // idling switches for the sender and the receiver
  bit in_idling  = 1'b1;
  bit out_idling = 1'b1;

  // free-running timestamps used by the random bursts
  logic [MS_W-1:0] cur_ms;
  logic [US_W-1:0] cur_us;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_flasher();
    shadow_cfg                  = '0;
    shadow_cfg.pulses_per_burst = 8'd1;
    flash_step    = STEP_IDLE;
    flash_mark_ms = '0;
    ramp_mark_us  = '0;
    pulses_done   = '0;
    brightness    = '0;
    going_up      = 1'b0;
    going_down    = 1'b0;
    lit_phase     = 1'b0;
  endfunction

  // wrapping elapsed-time test, shared by the ms and us timers
  function automatic bit span_passed(input logic [31:0] now, input logic [31:0] mark,
                                     input logic [TIME_W-1:0] span);
    logic [31:0] diff;
    diff = now - mark;
    return diff >= {16'd0, span};
  endfunction

  // one step of the flash sequence plus the brightness ramp
  function automatic drive_t advance_flasher(input logic [MS_W-1:0] ms,
                                             input logic [US_W-1:0] us, input logic restart);
    drive_t d;
    // restart only rewinds the sequence, the ramp state is kept
    if (restart) begin
      flash_step  = STEP_IDLE;
      pulses_done = '0;
    end

    case (flash_step)
      STEP_IDLE: begin
        flash_mark_ms = ms;
        flash_step    = STEP_DELAY;
      end
      STEP_DELAY: begin
        if (span_passed(ms, flash_mark_ms, shadow_cfg.start_delay_ms)) flash_step = STEP_ON;
      end
      STEP_ON: begin
        going_up      = 1'b1;
        going_down    = 1'b0;
        pulses_done   = pulses_done + 8'd1;
        flash_mark_ms = ms;
        flash_step    = STEP_ON_TIME;
        lit_phase     = 1'b1;
      end
      STEP_ON_TIME: begin
        if (span_passed(ms, flash_mark_ms, shadow_cfg.on_time_ms)) begin
          flash_step = STEP_OFF;
          lit_phase  = 1'b0;
        end
      end
      STEP_OFF: begin
        going_down    = 1'b1;
        going_up      = 1'b0;
        flash_mark_ms = ms;
        flash_step    = STEP_OFF_TIME;
      end
      STEP_OFF_TIME: begin
        if (span_passed(ms, flash_mark_ms, shadow_cfg.off_time_ms)) flash_step = STEP_COUNT;
      end
      STEP_COUNT: begin
        // a burst of zero pulses still ends after the first one
        if (pulses_done >= shadow_cfg.pulses_per_burst) begin
          pulses_done   = '0;
          flash_mark_ms = ms;
          flash_step    = STEP_PAUSE;
        end else begin
          flash_step = STEP_ON;
        end
      end
      default: begin
        if (span_passed(ms, flash_mark_ms, shadow_cfg.pause_time_ms)) flash_step = STEP_ON;
      end
    endcase

    if (shadow_cfg.ramp_step_us != '0) begin
      // one level per ramp interval; a dim level above the current one holds the fall open
      if (span_passed(us, ramp_mark_us, shadow_cfg.ramp_step_us)) begin
        ramp_mark_us = us;
        if (going_up && brightness < FULL_LEVEL) brightness = brightness + 8'd1;
        if (brightness == FULL_LEVEL || going_down) going_up = 1'b0;
        if (going_down && brightness > shadow_cfg.dim_level) brightness = brightness - 8'd1;
        if (brightness == shadow_cfg.dim_level) going_down = 1'b0;
      end
    end else begin
      if (going_up) begin
        brightness = FULL_LEVEL;
        going_up   = 1'b0;
      end
      if (going_down) begin
        brightness = shadow_cfg.dim_level;
        going_down = 1'b0;
      end
    end

    d.led_level      = shadow_cfg.invert_output ? FULL_LEVEL - brightness : brightness;
    d.pulse_on_phase = lit_phase;
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly back to back, often a short gap, now and then a long one
  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic lfs_cfg_t flash_config(input int unsigned on_ms, input int unsigned off_ms,
                                            input int unsigned pause_ms,
                                            input int unsigned delay_ms,
                                            input int unsigned pulses,
                                            input int unsigned ramp_us, input int unsigned dim,
                                            input bit inv);
    lfs_cfg_t c;
    c.on_time_ms       = on_ms[TIME_W-1:0];
    c.off_time_ms      = off_ms[TIME_W-1:0];
    c.pause_time_ms    = pause_ms[TIME_W-1:0];
    c.start_delay_ms   = delay_ms[TIME_W-1:0];
    c.pulses_per_burst = pulses[COUNT_W-1:0];
    c.ramp_step_us     = ramp_us[TIME_W-1:0];
    c.dim_level        = dim[LEVEL_W-1:0];
    c.invert_output    = inv;
    return c;
  endfunction

  // write enable is left high, the caller lowers it after the last write
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_ON_TIME:     shadow_cfg.on_time_ms       = data;
      CFG_OFF_TIME:    shadow_cfg.off_time_ms      = data;
      CFG_PAUSE_TIME:  shadow_cfg.pause_time_ms    = data;
      CFG_START_DELAY: shadow_cfg.start_delay_ms   = data;
      CFG_PULSES:      shadow_cfg.pulses_per_burst = data[COUNT_W-1:0];
      CFG_RAMP_STEP:   shadow_cfg.ramp_step_us     = data;
      CFG_DIM_LEVEL:   shadow_cfg.dim_level        = data[LEVEL_W-1:0];
      default:         shadow_cfg.invert_output    = data[0];
    endcase
  endtask

  // every register is written each time, only while the block is idle
  task automatic load_config(input lfs_cfg_t c);
    write_reg(CFG_ON_TIME,     c.on_time_ms);
    write_reg(CFG_OFF_TIME,    c.off_time_ms);
    write_reg(CFG_PAUSE_TIME,  c.pause_time_ms);
    write_reg(CFG_START_DELAY, c.start_delay_ms);
    write_reg(CFG_PULSES,      {8'd0, c.pulses_per_burst});
    write_reg(CFG_RAMP_STEP,   c.ramp_step_us);
    write_reg(CFG_DIM_LEVEL,   {8'd0, c.dim_level});
    write_reg(CFG_INVERT,      {15'd0, c.invert_output});
    cfg_we <= 1'b0;
  endtask

  // valid stays high on return so that a following transaction can go back to back
  task automatic send_item(input logic [MS_W-1:0] ms, input logic [US_W-1:0] us,
                           input logic restart);
    int unsigned gap;
    gap = pick_gap(in_idling);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.now_ms  <= ms;
    in_ch.now_us  <= us;
    in_ch.restart <= restart;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_drive.push_back(advance_flasher(ms, us, restart));
  endtask

  // stop sending and let every owed result come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  // receiver stalls, drawn from the same gap mix as the sender
  initial begin
    int unsigned hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        hold = pick_gap(out_idling);
      end
    end
  end

  always @(posedge clk) begin : check_drive
    drive_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_drive.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result transaction: level %0d on %0b",
                   out_ch.led_level, out_ch.pulse_on_phase);
        mismatch_count++;
      end else begin
        want = expected_drive.pop_front();
        if (out_ch.led_level !== want.led_level ||
            out_ch.pulse_on_phase !== want.pulse_on_phase) begin
          if (mismatch_count < 10)
            $display("drive mismatch: expected level %0d on %0b, got level %0d on %0b",
                     want.led_level, want.pulse_on_phase,
                     out_ch.led_level, out_ch.pulse_on_phase);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // registers at their reset values, timestamps at their extremes and alternating bits
  task automatic test_reset_defaults();
    send_item(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_item(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    send_item(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
  endtask

  // start delay across the ms wrap, zero pulses per burst, inverted drive, restart as a pulse is due
  task automatic test_wrap_zero_pulses();
    drain();
    load_config(flash_config(2, 1, 3, 20, 0, 0, 200, 1'b1));
    send_item(32'hFFFF_FFF0, 32'd0, 1'b1);
    send_item(32'h0000_0003, 32'd1, 1'b0);   // one ms short of the delay
    send_item(32'h0000_0004, 32'd2, 1'b0);   // delay just reached
    send_item(32'h0000_0004, 32'd3, 1'b0);
    send_item(32'h0000_0005, 32'd4, 1'b0);
    send_item(32'h0000_0006, 32'd5, 1'b0);
    send_item(32'h0000_0006, 32'd6, 1'b0);
    send_item(32'h0000_0007, 32'd7, 1'b0);
    send_item(32'h0000_0007, 32'd8, 1'b0);   // count check with a zero burst length
    send_item(32'h0000_000A, 32'd9, 1'b0);
    send_item(32'h0000_000B, 32'd10, 1'b1);
  endtask

  // a dim level above the current brightness leaves the fall pending
  task automatic test_dim_above_level();
    drain();
    load_config(flash_config(0, 0, 0, 0, 2, 0, 0, 1'b0));
    send_item(32'd100, 32'd0, 1'b1);
    repeat (4) send_item(32'd101, 32'd0, 1'b0);
    drain();
    load_config(flash_config(0, 0, 0, 0, 2, 5, 200, 1'b0));
    for (int i = 1; i <= 6; i++) send_item(32'd101 + i, 32'd5 * i, 1'b0);
  endtask

  // bursts with random content: mostly steady time, some jumps and restarts
  task automatic run_flash_phase(input lfs_cfg_t c, input int n_items, input bit idle);
    int unsigned ms_stride;
    int unsigned us_stride;
    int unsigned hold_at;
    int unsigned r;
    drain();
    load_config(c);
    in_idling  = idle;
    out_idling = idle;
    // time steps scaled to the configured spans so that every step is reached
    ms_stride = c.on_time_ms;
    if (c.off_time_ms > ms_stride) ms_stride = c.off_time_ms;
    if (c.pause_time_ms > ms_stride) ms_stride = c.pause_time_ms;
    if (c.start_delay_ms > ms_stride) ms_stride = c.start_delay_ms;
    ms_stride = ms_stride / 3 + 1;
    us_stride = (c.ramp_step_us != '0) ? 2 * c.ramp_step_us + 1 : 1000;
    // start some phases just below the wrap of both timers
    if ($urandom_range(0, 2) == 0) begin
      cur_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * ms_stride);
      cur_us = 32'hFFFF_FFFF - $urandom_range(0, 4 * us_stride);
    end else begin
      cur_ms = $urandom;
      cur_us = $urandom;
    end
    hold_at = $urandom_range(1, n_items - 1);
    for (int i = 0; i < n_items; i++) begin
      // sender holds off until every owed result is out
      if (i == hold_at) drain();
      r = $urandom_range(0, 99);
      if (r < 8) begin
        cur_ms = $urandom;
        cur_us = $urandom;
      end else begin
        cur_ms = cur_ms + $urandom_range(0, ms_stride);
        cur_us = cur_us + $urandom_range(0, us_stride);
      end
      send_item(cur_ms, cur_us, (r >= 95) || (r < 8 && r[0]));
    end
  endtask

  task automatic test_random_bursts();
    // lowest settings with the longest burst, then every register at its top
    run_flash_phase(flash_config(0, 0, 0, 0, 255, 0, 0, 1'b0), 100, 1'b1);
    run_flash_phase(flash_config(65535, 65535, 65535, 65535, 255, 65535, 255, 1'b1),
                    100, 1'b1);
    for (int p = 0; p < 7; p++) begin
      if (p < 5)
        run_flash_phase(flash_config($urandom_range(0, 12), $urandom_range(0, 12),
                                     $urandom_range(0, 20), $urandom_range(0, 15),
                                     $urandom_range(0, 5), $urandom_range(0, 6),
                                     $urandom_range(0, 255), $urandom_range(0, 1)),
                        100, p % 3 != 2);
      else
        run_flash_phase(flash_config($urandom_range(0, 65535), $urandom_range(0, 65535),
                                     $urandom_range(0, 65535), $urandom_range(0, 65535),
                                     $urandom_range(0, 255), $urandom_range(0, 65535),
                                     $urandom_range(0, 255), $urandom_range(0, 1)),
                        100, p % 2 == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence of tests
  // ---------------------------------------------------------------------------

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_ON_TIME;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.now_ms  <= '0;
    in_ch.now_us  <= '0;
    in_ch.restart <= 1'b0;
    clear_flasher();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_wrap_zero_pulses();
    test_dim_above_level();
    test_random_bursts();

    // all results in, then a last wait for anything stray
    drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- led_flash_sequencer.f -----
+incdir+sv
sv/lfs_pkg.sv
sv/lfs_if.sv
sv/lfs_seq.sv
sv/lfs_ramp.sv
sv/led_flash_sequencer.sv
test/led_flash_sequencer_tb.sv
